// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none
package wsd_pkg;

   // result kind codes
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_HEADER  = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // header byte fields
   localparam logic [7:0] HDR_TOP_BIT  = 8'h80;
   localparam logic [7:0] HDR_LEN_MASK = 8'h7f;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_start;
   } wsd_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [63:0] payload_length;
      logic        fin_flag;
      logic        last;
   } wsd_rsp_type;

   // classified work handed from the parser to the output stage
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [7:0]  key_byte;
      logic [63:0] length;
      logic        fin;
      logic        last;
   } wsd_cmd_type;

   typedef enum logic [5:0] {
      PH_IDLE    = 6'b000001,
      PH_HDR1    = 6'b000010,
      PH_EXT     = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_DISCARD = 6'b100000
   } wsd_phase_type;

endpackage
`default_nettype wire

// ===== rtl/wsd_front.sv =====
// Front end: frame header parser, turns each accepted byte into at most one command.
// Depends on wsd_pkg.
`default_nettype none
module wsd_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire wsd_pkg::wsd_req_type req,
   output logic                      cmd_push,
   output wsd_pkg::wsd_cmd_type      cmd
);
   import wsd_pkg::*;

   wsd_phase_type phase_ff, phase_in;
   logic [3:0]    ext_left_ff, ext_left_in;
   logic [63:0]   accum_ff, accum_in;
   logic [31:0]   key_ff, key_in;
   logic [1:0]    key_seen_ff, key_seen_in;
   logic [1:0]    idx_ff, idx_in;
   logic [63:0]   left_ff, left_in;
   logic          fin_ff, fin_in;

   logic          hdr_done;
   logic [63:0]   hdr_len;
   logic [6:0]    len7;
   logic [7:0]    kb;
   logic [63:0]   shifted;

   assign len7    = 7'(req.in_byte & HDR_LEN_MASK);
   assign shifted = {accum_ff[55:0], req.in_byte};

   always_comb begin
      case (idx_ff)
         2'd0:    kb = key_ff[31:24];
         2'd1:    kb = key_ff[23:16];
         2'd2:    kb = key_ff[15:8];
         default: kb = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      ext_left_in = ext_left_ff;
      accum_in    = accum_ff;
      key_in      = key_ff;
      key_seen_in = key_seen_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      fin_in      = fin_ff;
      hdr_done    = 1'b0;
      hdr_len     = '0;
      cmd_push    = 1'b0;
      cmd         = '0;
      cmd.fin     = fin_ff;
      if (accept) begin
         if (req.frame_start) begin
            fin_in      = (req.in_byte & HDR_TOP_BIT) != 8'h00;
            ext_left_in = '0;
            accum_in    = '0;
            key_in      = '0;
            key_seen_in = '0;
            idx_in      = '0;
            left_in     = '0;
            phase_in    = PH_HDR1;
         end else begin
            case (phase_ff)
               PH_HDR1: begin
                  if ((req.in_byte & HDR_TOP_BIT) == 8'h00) begin
                     // unmasked client frame
                     phase_in = PH_DISCARD;
                     cmd_push = 1'b1;
                     cmd.kind = KIND_ERROR;
                  end else if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
                     ext_left_in = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                     accum_in    = '0;
                     phase_in    = PH_EXT;
                  end else begin
                     hdr_done = 1'b1;
                     hdr_len  = 64'(len7);
                  end
               end
               PH_EXT: begin
                  accum_in    = shifted;
                  ext_left_in = ext_left_ff - 4'd1;
                  if (ext_left_ff == 4'd1) begin
                     hdr_done = 1'b1;
                     hdr_len  = shifted;
                  end
               end
               PH_KEY: begin
                  key_in      = {key_ff[23:0], req.in_byte};
                  key_seen_in = key_seen_ff + 2'd1;
                  if (key_seen_ff == 2'd3) begin
                     phase_in = (left_ff == 64'd0) ? PH_IDLE : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  idx_in       = idx_ff + 2'd1;
                  left_in      = left_ff - 64'd1;
                  cmd_push     = 1'b1;
                  cmd.kind     = KIND_PAYLOAD;
                  cmd.data     = req.in_byte;
                  cmd.key_byte = kb;
                  cmd.last     = (left_ff == 64'd1);
                  if (left_ff == 64'd1) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
            if (hdr_done) begin
               left_in     = hdr_len;
               key_in      = '0;
               key_seen_in = '0;
               idx_in      = '0;
               phase_in    = PH_KEY;
               cmd_push    = 1'b1;
               cmd.kind    = KIND_HEADER;
               cmd.length  = hdr_len;
               cmd.last    = (hdr_len == 64'd0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         ext_left_ff <= '0;
         accum_ff    <= '0;
         key_ff      <= '0;
         key_seen_ff <= '0;
         idx_ff      <= '0;
         left_ff     <= '0;
         fin_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         ext_left_ff <= ext_left_in;
         accum_ff    <= accum_in;
         key_ff      <= key_in;
         key_seen_ff <= key_seen_in;
         idx_ff      <= idx_in;
         left_ff     <= left_in;
         fin_ff      <= fin_in;
      end
   end

`ifndef SYNTH
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> accept)
      else $error("command without accepted byte");
   a_payload_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != 64'd0)
      else $error("payload phase with nothing left");
   a_ext_left_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_EXT |-> (ext_left_ff != 4'd0 && ext_left_ff <= EXT64_BYTES))
      else $error("extended length count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/wsd_queue.sv =====
// Short command queue decoupling the parser from the output stage.
// Depends on wsd_pkg.
`default_nettype none
module wsd_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire wsd_pkg::wsd_cmd_type push_data,
   input  wire logic                 pop,
   output wsd_pkg::wsd_cmd_type      pop_data,
   output logic                      full,
   output logic                      empty
);
   import wsd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   wsd_cmd_type   slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_SLOT) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_SLOT) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/wsd_back.sv =====
// Back end: unmasks payload bytes and holds the result register toward the consumer.
// Depends on wsd_pkg.
`default_nettype none
module wsd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_avail,
   input  wire wsd_pkg::wsd_cmd_type cmd,
   output logic                      cmd_take,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output wsd_pkg::wsd_rsp_type      rsp_item
);
   import wsd_pkg::*;

   logic        valid_ff, valid_in;
   wsd_rsp_type rsp_ff, rsp_in;
   logic        out_pop;

   assign out_pop   = valid_ff && rsp_pop;
   assign cmd_take  = cmd_avail && (!valid_ff || rsp_pop);
   assign rsp_empty = !valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      rsp_in                = rsp_ff;
      valid_in              = valid_ff && !out_pop;
      if (cmd_take) begin
         valid_in              = 1'b1;
         rsp_in.kind           = cmd.kind;
         rsp_in.payload_byte   = cmd.data ^ cmd.key_byte;
         rsp_in.payload_length = cmd.length;
         rsp_in.fin_flag       = cmd.fin;
         rsp_in.last           = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> (!valid_ff || rsp_pop))
      else $error("result register overwritten");
   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=> (valid_ff && rsp_ff == $past(rsp_ff)))
      else $error("waiting result changed");
   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rsp_ff.kind == KIND_PAYLOAD || rsp_ff.kind == KIND_HEADER ||
                    rsp_ff.kind == KIND_ERROR))
      else $error("bad result kind");
`endif

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// Client WebSocket frame deframer: one byte in per cycle while req_full is low,
// header/payload/error results out through the command queue, then the result register.
// Throughput: one byte per cycle sustained while req_full is low; the queue and result
// register absorb up to QUEUE_DEPTH+1 results of consumer stall before req_full rises.
// Reset: synchronous, active high; parser returns to idle, queue and result register empty.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
`default_nettype none
module websocket_frame_deframer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // byte input
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire wsd_pkg::wsd_req_type req_item,
   // result output
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output wsd_pkg::wsd_rsp_type      rsp_item
);
   import wsd_pkg::*;

   logic        in_accept;
   logic        cmd_push;
   wsd_cmd_type cmd_in;
   wsd_cmd_type cmd_out;
   logic        q_full;
   logic        q_empty;
   logic        cmd_take;

   // the parser never stalls by itself: input waits only on queue space
   assign req_full  = q_full;
   assign in_accept = req_push && !q_full;

   // front: phase tracking, length assembly, key capture, key byte select
   wsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (in_accept),
      .req      (req_item),
      .cmd_push (cmd_push),
      .cmd      (cmd_in)
   );

   // decoupling queue, one entry per emitted result
   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_take),
      .pop_data  (cmd_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: unmask and present the oldest result
   wsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_avail (!q_empty),
      .cmd       (cmd_out),
      .cmd_take  (cmd_take),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
